/* rtl/twpc_pkg.sv */
`default_nettype none

package twpc_pkg;

    // Field widths on the stream ports.
    localparam int BaseW   = 32;
    localparam int CoordW  = 16;
    localparam int ReadyW  = 32;
    localparam int DueW    = 32;
    localparam int ServW   = 24;
    localparam int ArrW    = 32;

    // Bit offsets of the input fields inside s_tdata.
    localparam int BaseLsb  = 0;
    localparam int XLsb     = BaseLsb + BaseW;
    localparam int YLsb     = XLsb + CoordW;
    localparam int ReadyLsb = YLsb + CoordW;
    localparam int DueLsb   = ReadyLsb + ReadyW;
    localparam int ServLsb  = DueLsb + DueW;
    localparam int InDataW  = ServLsb + ServW;

    localparam int OutPad   = 6;
    localparam int OutDataW = ArrW + 2 + OutPad;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_ARRIVE,
        ST_DEPART
    } twpc_state_t;

    // Control from the sequencer to the time window unit.
    typedef struct packed {
        logic load_arrival;
        logic commit;
        logic first;
    } twpc_win_ctrl_t;

    // Result of the time window unit for the node being committed.
    typedef struct packed {
        logic [ArrW-1:0] arrival;
        logic            late;
        logic            feasible;
    } twpc_win_res_t;

endpackage

`default_nettype wire

/* rtl/twpc_isqrt.sv */
`default_nettype none

// Restoring integer square root, one root bit per cycle.
module twpc_isqrt
    import twpc_pkg::*;
#(
    parameter int ROOT_BITS = 17
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [2*ROOT_BITS-1:0] radicand,
    output logic                        done,
    output logic [ROOT_BITS-1:0]        root
);

    localparam int RadW = 2 * ROOT_BITS;
    localparam int CntW = $clog2(ROOT_BITS + 1);

    logic [CntW-1:0]      cnt_reg;
    logic [RadW-1:0]      rad_reg;
    logic [ROOT_BITS:0]   rem_reg;
    logic [ROOT_BITS-1:0] root_reg;

    logic [ROOT_BITS+2:0] rem_cat;
    logic [ROOT_BITS+2:0] trial;
    logic [ROOT_BITS+2:0] diff;
    logic                 ge;
    logic [ROOT_BITS:0]   rem_next;
    logic [ROOT_BITS-1:0] root_next;

    always_comb
    begin
        rem_cat   = {rem_reg, rad_reg[RadW-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        ge        = (rem_cat >= trial);
        diff      = rem_cat - trial;
        rem_next  = ge ? diff[ROOT_BITS:0] : rem_cat[ROOT_BITS:0];
        root_next = {root_reg[ROOT_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CntW'(ROOT_BITS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rad_reg  <= {rad_reg[RadW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    // The last iteration is under way; the root is final on the next cycle.
    assign done = (cnt_reg == CntW'(1));
    assign root = root_reg;

endmodule

`default_nettype wire

/* rtl/twpc_window.sv */
`default_nettype none

// Arrival, lateness and departure bookkeeping, in two steps per node.
module twpc_window
    import twpc_pkg::*;
#(
    parameter int TIME_BITS = 32,
    parameter int DIST_BITS = 17
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire twpc_win_ctrl_t        ctrl,
    input  wire logic [DIST_BITS-1:0]  hop_len,
    input  wire logic [BaseW-1:0]      base_time,
    input  wire logic [ReadyW-1:0]     ready_time,
    input  wire logic [DueW-1:0]       due_time,
    input  wire logic [ServW-1:0]      service_time,
    output twpc_win_res_t              res
);

    localparam int CmpW = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int SumW = CmpW + 1;
    localparam logic [SumW-1:0] TimeMax = (SumW'(1) << TIME_BITS) - SumW'(1);

    logic [TIME_BITS-1:0] arrival_reg;
    logic [TIME_BITS-1:0] depart_reg;
    logic                 route_ok_reg;

    logic [SumW-1:0]      base_x;
    logic [SumW-1:0]      base_c;
    logic [SumW-1:0]      run_sum;
    logic [SumW-1:0]      run_c;
    logic [TIME_BITS-1:0] arrival_next;
    logic [SumW-1:0]      arr_x;
    logic [SumW-1:0]      ready_x;
    logic [SumW-1:0]      start_t;
    logic [SumW-1:0]      dep_sum;
    logic [SumW-1:0]      dep_c;
    logic                 late;
    logic                 feasible;

    always_comb
    begin
        base_x       = SumW'(base_time);
        base_c       = (base_x > TimeMax) ? TimeMax : base_x;
        run_sum      = SumW'(depart_reg) + SumW'(hop_len);
        run_c        = (run_sum > TimeMax) ? TimeMax : run_sum;
        arrival_next = ctrl.first ? base_c[TIME_BITS-1:0] : run_c[TIME_BITS-1:0];

        arr_x    = SumW'(arrival_reg);
        ready_x  = SumW'(ready_time);
        late     = !ctrl.first && (arr_x > SumW'(due_time));
        feasible = ctrl.first || (route_ok_reg && !late);
        // Waiting for the window to open, then serving.
        start_t  = (arr_x < ready_x) ? ready_x : arr_x;
        dep_sum  = start_t + SumW'(service_time);
        dep_c    = (dep_sum > TimeMax) ? TimeMax : dep_sum;

        res.arrival  = arr_x[ArrW-1:0];
        res.late     = late;
        res.feasible = feasible;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depart_reg   <= '0;
            route_ok_reg <= 1'b1;
        end
        else if (ctrl.commit)
        begin
            depart_reg   <= dep_c[TIME_BITS-1:0];
            route_ok_reg <= feasible;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_arrival)
        begin
            arrival_reg <= arrival_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/time_window_propagation_check_unit.sv */
`default_nettype none

// Time window check along a vehicle route. Nodes arrive one beat at a time in
// visiting order; a beat with s_tuser high starts a new route and takes its
// base time as arrival. For every other node the unit measures the Euclidean
// distance from the previous node (integer square root of dx*dx + dy*dy on
// the raw Q8.8 coordinates), adds it to the previous departure time, flags
// the node late when that arrival exceeds its due time, and computes the
// departure as the arrival raised to the ready time plus the service time.
// All times saturate at 2^TIME_BITS-1. One result beat leaves per node.
// A start node goes from acceptance straight to the arrival and departure
// steps; any other node first passes through the squaring states ST_SQX and
// ST_SQY and the square root unit, where R = min(COORD_BITS,16) + 1 is the
// number of root bits. The square root unit retires one root bit per cycle,
// the squares are formed on one shared multiplier, and the departure step
// holds while the output register is full. A finished result waits in the output
// register, so the next node is taken in while the result is still unread.
module time_window_propagation_check_unit
    import twpc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int TIME_BITS  = 32
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // base_time[31:0], x[47:32], y[63:48], ready_time[95:64],
    // due_time[127:96], service_time[151:128]
    input  wire logic [InDataW-1:0]  s_tdata,
    // first
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // arrival[31:0], late[32], feasible[33], zero[39:34]
    output logic [OutDataW-1:0]      m_tdata
);

    // Coordinates are 16 bits on the port; narrower settings mask them.
    localparam int Cw       = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;
    localparam int RootBits = Cw + 1;
    localparam int SqW      = 2 * Cw;
    localparam int RadW     = 2 * RootBits;

    twpc_state_t state_reg;
    twpc_state_t state_next;

    logic                first_reg;
    logic [BaseW-1:0]    base_reg;
    logic [Cw-1:0]       x_reg;
    logic [Cw-1:0]       y_reg;
    logic [ReadyW-1:0]   ready_reg;
    logic [DueW-1:0]     due_reg;
    logic [ServW-1:0]    service_reg;
    logic [Cw-1:0]       prev_x_reg;
    logic [Cw-1:0]       prev_y_reg;
    logic [SqW:0]        sum_reg;

    logic                m_tvalid_reg;
    logic [OutDataW-1:0] m_tdata_reg;

    logic                accept;
    logic                out_load;
    logic                root_start;
    logic                root_done;
    logic [RootBits-1:0] hop_len;
    logic [Cw-1:0]       dx;
    logic [Cw-1:0]       dy;
    logic [Cw-1:0]       mul_op;
    logic [SqW-1:0]      sq;
    logic [RadW-1:0]     radicand;
    twpc_win_ctrl_t      win_ctrl;
    twpc_win_res_t       win_res;

    assign accept = s_tvalid && s_tready;

    // Sequencer: capture, squaring of dx and dy, serial root, two time steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next            = state_reg;
        s_tready              = 1'b0;
        root_start            = 1'b0;
        out_load              = 1'b0;
        win_ctrl.load_arrival = 1'b0;
        win_ctrl.commit       = 1'b0;
        win_ctrl.first        = first_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = s_tuser ? ST_ARRIVE : ST_SQX;
                end
            end
            ST_SQX:
            begin
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                root_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = ST_ARRIVE;
                end
            end
            ST_ARRIVE:
            begin
                win_ctrl.load_arrival = 1'b1;
                state_next            = ST_DEPART;
            end
            ST_DEPART:
            begin
                // Hold here until the output register can take the result.
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load        = 1'b1;
                    win_ctrl.commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Node fields are held for the whole computation.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_reg   <= s_tuser;
            base_reg    <= s_tdata[BaseLsb +: BaseW];
            x_reg       <= s_tdata[XLsb +: Cw];
            y_reg       <= s_tdata[YLsb +: Cw];
            ready_reg   <= s_tdata[ReadyLsb +: ReadyW];
            due_reg     <= s_tdata[DueLsb +: DueW];
            service_reg <= s_tdata[ServLsb +: ServW];
        end
    end

    // Previous node position; after reset, a route with no start node begins at the origin.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end
        else if (out_load)
        begin
            prev_x_reg <= x_reg;
            prev_y_reg <= y_reg;
        end
    end

    // One multiplier serves both squares on successive cycles.
    always_comb
    begin
        dx       = (x_reg >= prev_x_reg) ? (x_reg - prev_x_reg) : (prev_x_reg - x_reg);
        dy       = (y_reg >= prev_y_reg) ? (y_reg - prev_y_reg) : (prev_y_reg - y_reg);
        mul_op   = (state_reg == ST_SQY) ? dy : dx;
        sq       = mul_op * mul_op;
        radicand = RadW'(sum_reg) + RadW'(sq);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SQX)
        begin
            sum_reg <= {1'b0, sq};
        end
    end

    twpc_isqrt #(
        .ROOT_BITS (RootBits)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (hop_len)
    );

    twpc_window #(
        .TIME_BITS (TIME_BITS),
        .DIST_BITS (RootBits)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (win_ctrl),
        .hop_len      (hop_len),
        .base_time    (base_reg),
        .ready_time   (ready_reg),
        .due_time     (due_reg),
        .service_time (service_reg),
        .res          (win_res)
    );

    // Output register: the result beat stays here until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {{OutPad{1'b0}}, win_res.feasible, win_res.late, win_res.arrival};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
